FILE: rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types, event codes and the firing delay table of the dimmer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned AdcW    = 10;
  localparam int unsigned KeyW    = 10;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LevelW  = 5;
  localparam int unsigned PctW    = 7;
  localparam int unsigned SrcW    = 2;
  localparam int unsigned DelayW  = 14;

  localparam logic [LevelW-1:0] MaxLevel  = 5'd20;
  localparam logic [LevelW-1:0] AdcReset  = 5'd20;
  localparam logic [ByteW-1:0]  LetterA   = 8'h61;
  localparam logic [ByteW-1:0]  LetterU   = 8'h75;
  localparam logic [6:0]        KeyClamp  = 7'd100;

  typedef enum logic [ModeW-1:0] {
    EV_TICK   = 3'd0,
    EV_ZERO   = 3'd1,
    EV_BUTTON = 3'd2,
    EV_ADC    = 3'd3,
    EV_KEYPAD = 3'd4,
    EV_UART   = 3'd5
  } event_e;

  typedef enum logic [SrcW-1:0] {
    SRC_ADC    = 2'd1,
    SRC_KEYPAD = 2'd2,
    SRC_REMOTE = 2'd3
  } source_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [AdcW-1:0]  adc_sample;
    logic [KeyW-1:0]  keypad_number;
    logic [ByteW-1:0] uart_byte;
  } ptd_item_t;

  // Firing delay in microseconds after the zero crossing, per level.
  function automatic logic [DelayW-1:0] fire_delay(input logic [LevelW-1:0] lv);
    logic [DelayW-1:0] d;
    case (lv)
      5'd0:    d = 14'd9800;
      5'd1:    d = 14'd9350;
      5'd2:    d = 14'd8900;
      5'd3:    d = 14'd8450;
      5'd4:    d = 14'd8000;
      5'd5:    d = 14'd7550;
      5'd6:    d = 14'd7100;
      5'd7:    d = 14'd6650;
      5'd8:    d = 14'd6200;
      5'd9:    d = 14'd5750;
      5'd10:   d = 14'd5300;
      5'd11:   d = 14'd4850;
      5'd12:   d = 14'd4400;
      5'd13:   d = 14'd3950;
      5'd14:   d = 14'd3500;
      5'd15:   d = 14'd3050;
      5'd16:   d = 14'd2800;
      5'd17:   d = 14'd2300;
      5'd18:   d = 14'd1900;
      5'd19:   d = 14'd1250;
      default: d = 14'd800;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/phase_angle_triac_dimmer.sv
// ----------------------------------------------------------------------------
// phase_angle_triac_dimmer
// Phase-angle triac dimmer: level source selection and gate firing timer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  event   | in        | in_valid_i / in_ready_o | mode_i, adc_sample_i,
//          |           |                         | keypad_number_i, uart_byte_i
//  status  | out       | out_valid_o/out_ready_i | gate_fire_o, level_o,
//          |           |                         | percent_o, source_o, armed_o
//
//  One event per cycle while the status side does not stall; the status beat
//  of an event passes through the input register, then the state and result
//  register. Rate is set by the single state update between those registers.
//  Reset puts the source at adc, adc level at 20, the counter disarmed.
//  A stall on the status side holds the result; in_ready_o drops at once when
//  the input register is full, or after one more event when it is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_angle_triac_dimmer import ptd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ModeW-1:0]  mode_i,
  input  wire logic [AdcW-1:0]   adc_sample_i,
  input  wire logic [KeyW-1:0]   keypad_number_i,
  input  wire logic [ByteW-1:0]  uart_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   gate_fire_o,
  output logic [LevelW-1:0]      level_o,
  output logic [PctW-1:0]        percent_o,
  output logic [SrcW-1:0]        source_o,
  output logic                   armed_o
);

  ptd_item_t in_item;
  ptd_item_t s1_item;
  logic      s1_valid;
  logic      core_ready;

  assign in_item.mode          = mode_i;
  assign in_item.adc_sample    = adc_sample_i;
  assign in_item.keypad_number = keypad_number_i;
  assign in_item.uart_byte     = uart_byte_i;

  ptd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .core_ready_i (core_ready),
    .valid_o      (s1_valid),
    .item_o       (s1_item)
  );

  ptd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .item_i      (s1_item),
    .ready_o     (core_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .gate_fire_o (gate_fire_o),
    .level_o     (level_o),
    .percent_o   (percent_o),
    .source_o    (source_o),
    .armed_o     (armed_o)
  );

endmodule

`default_nettype wire

FILE: rtl/ptd_in_stage.sv
// ----------------------------------------------------------------------------
// ptd_in_stage
// Input register: captures one event beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_in_stage import ptd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire ptd_item_t item_i,
  input  wire logic      core_ready_i,
  output logic           valid_o,
  output ptd_item_t      item_o
);

  logic      valid_q, valid_d;
  ptd_item_t item_q;
  logic      take;

  assign take       = valid_q & core_ready_i;
  assign in_ready_o = ~valid_q | core_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end else if (take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: rtl/ptd_core.sv
// ----------------------------------------------------------------------------
// ptd_core
// Dimmer state update and result register: one event per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_core import ptd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire ptd_item_t  item_i,
  output logic            ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            gate_fire_o,
  output logic [LevelW-1:0] level_o,
  output logic [PctW-1:0]   percent_o,
  output logic [SrcW-1:0]   source_o,
  output logic              armed_o
);

  logic [SrcW-1:0]   source_q, source_d;
  logic [LevelW-1:0] adc_level_q, adc_level_d;
  logic [LevelW-1:0] key_level_q, key_level_d;
  logic              key_valid_q, key_valid_d;
  logic [LevelW-1:0] remote_level_q, remote_level_d;
  logic [LevelW-1:0] active_level_q, active_level_d;
  logic [DelayW-1:0] delay_target_q, delay_target_d;
  logic [DelayW-1:0] tick_count_q, tick_count_d;
  logic              armed_q, armed_d;
  logic              fire_q, fire_d;
  logic              out_valid_q, out_valid_d;
  logic              adv;

  // Level from adc: sample*20/1023 as shift by 1024 plus one correction.
  logic [14:0]       adc_prod;
  logic [LevelW-1:0] adc_q0;
  logic [10:0]       adc_rem;
  logic [LevelW-1:0] adc_new;

  // Level from keypad: (min(n,100)+2)/5 through reciprocal 205/1024.
  logic [6:0]        key_clamp;
  logic [6:0]        key_sum;
  logic [14:0]       key_prod;
  logic [LevelW-1:0] key_new;

  logic [DelayW-1:0] tick_next;
  logic [LevelW-1:0] zc_level;

  assign ready_o = ~out_valid_q | out_ready_i;
  assign adv     = valid_i & ready_o;

  assign adc_prod = 15'(item_i.adc_sample) * 15'd20;
  assign adc_q0   = adc_prod[14:10];
  assign adc_rem  = {1'b0, adc_prod[9:0]} + 11'(adc_q0);
  assign adc_new  = adc_q0 + LevelW'(adc_rem >= 11'd1023);

  assign key_clamp = (item_i.keypad_number > 10'(KeyClamp)) ? KeyClamp
                                                            : item_i.keypad_number[6:0];
  assign key_sum   = key_clamp + 7'd2;
  assign key_prod  = 15'(key_sum) * 15'd205;
  assign key_new   = key_prod[14:10];

  assign tick_next = tick_count_q + 14'd1;

  always_comb begin
    zc_level = active_level_q;
    if (source_q == SRC_ADC) begin
      zc_level = adc_level_q;
    end else if (key_valid_q) begin
      zc_level = key_level_q;
    end else if (source_q == SRC_REMOTE) begin
      zc_level = remote_level_q;
    end
    if (zc_level > MaxLevel) begin
      zc_level = MaxLevel;
    end
  end

  always_comb begin
    source_d       = source_q;
    adc_level_d    = adc_level_q;
    key_level_d    = key_level_q;
    key_valid_d    = key_valid_q;
    remote_level_d = remote_level_q;
    active_level_d = active_level_q;
    delay_target_d = delay_target_q;
    tick_count_d   = tick_count_q;
    armed_d        = armed_q;
    fire_d         = fire_q;
    out_valid_d    = out_valid_q & ~out_ready_i;
    if (adv) begin
      out_valid_d = 1'b1;
      fire_d      = 1'b0;
      case (item_i.mode)
        EV_TICK: begin
          if (armed_q) begin
            tick_count_d = tick_next;
            if (tick_next >= delay_target_q) begin
              fire_d  = 1'b1;
              armed_d = 1'b0;
            end
          end
        end
        EV_ZERO: begin
          active_level_d = zc_level;
          delay_target_d = fire_delay(zc_level);
          tick_count_d   = '0;
          armed_d        = 1'b1;
        end
        EV_BUTTON: begin
          source_d    = (source_q == SRC_REMOTE) ? SRC_ADC : source_q + 2'd1;
          key_valid_d = 1'b0;
        end
        EV_ADC: begin
          if (source_q == SRC_ADC) begin
            adc_level_d = adc_new;
          end
        end
        EV_KEYPAD: begin
          if (source_q == SRC_KEYPAD) begin
            key_level_d = key_new;
            key_valid_d = 1'b1;
          end
        end
        EV_UART: begin
          if (source_q == SRC_REMOTE && item_i.uart_byte >= LetterA &&
              item_i.uart_byte <= LetterU) begin
            remote_level_d = LevelW'(item_i.uart_byte - LetterA);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q       <= SRC_ADC;
      adc_level_q    <= AdcReset;
      key_level_q    <= '0;
      key_valid_q    <= 1'b0;
      remote_level_q <= '0;
      active_level_q <= '0;
      delay_target_q <= '0;
      tick_count_q   <= '0;
      armed_q        <= 1'b0;
      fire_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      source_q       <= source_d;
      adc_level_q    <= adc_level_d;
      key_level_q    <= key_level_d;
      key_valid_q    <= key_valid_d;
      remote_level_q <= remote_level_d;
      active_level_q <= active_level_d;
      delay_target_q <= delay_target_d;
      tick_count_q   <= tick_count_d;
      armed_q        <= armed_d;
      fire_q         <= fire_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // State only moves on an accepted beat, so it doubles as the result register.
  assign out_valid_o = out_valid_q;
  assign gate_fire_o = fire_q;
  assign level_o     = active_level_q;
  assign percent_o   = {active_level_q, 2'b00} + PctW'(active_level_q);
  assign source_o    = source_q;
  assign armed_o     = armed_q;

  a_fire_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_q |-> !armed_q)
    else $error("gate fired while counter still armed");

  a_count_below_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (tick_count_q < delay_target_q))
    else $error("armed counter reached its target without firing");

  a_zero_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && item_i.mode == EV_ZERO) |=> (armed_q && tick_count_q == '0))
    else $error("zero crossing did not arm the counter");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_level_q <= MaxLevel) && (adc_level_q <= MaxLevel) &&
    (key_level_q <= MaxLevel) && (remote_level_q <= MaxLevel))
    else $error("level out of range");

  a_key_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_q |-> (source_q == SRC_KEYPAD))
    else $error("keypad entry valid outside keypad source");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the phase-angle triac dimmer. A shadow model of the
// dimmer state predicts one status beat per accepted event; a monitor pops
// the prediction for each status beat and compares every field. Directed
// tests walk the three level sources, the keypad clamp, the remote letters,
// the reserved event codes, a count restart and gate firing at the shortest
// delay. Random half-cycles follow: level setup, a zero crossing, then a few
// ticks. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ptd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ModeW-1:0] EV_SPARE6 = 3'd6;
  localparam logic [ModeW-1:0] EV_SPARE7 = 3'd7;
  localparam int unsigned NumHalfCycles = 12;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned LimitCycles   = 200_000;

  // Firing delay in microseconds per level
  localparam logic [DelayW-1:0] FireUs [0:20] = '{
    14'd9800, 14'd9350, 14'd8900, 14'd8450, 14'd8000, 14'd7550, 14'd7100,
    14'd6650, 14'd6200, 14'd5750, 14'd5300, 14'd4850, 14'd4400, 14'd3950,
    14'd3500, 14'd3050, 14'd2800, 14'd2300, 14'd1900, 14'd1250, 14'd800
  };

  typedef struct packed {
    logic              gate_fire;
    logic [LevelW-1:0] level;
    logic [PctW-1:0]   percent;
    logic [SrcW-1:0]   source;
    logic              armed;
  } status_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic [ModeW-1:0]  mode_i          = '0;
  logic [AdcW-1:0]   adc_sample_i    = '0;
  logic [KeyW-1:0]   keypad_number_i = '0;
  logic [ByteW-1:0]  uart_byte_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b1;
  logic              gate_fire_o;
  logic [LevelW-1:0] level_o;
  logic [PctW-1:0]   percent_o;
  logic [SrcW-1:0]   source_o;
  logic              armed_o;

  phase_angle_triac_dimmer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .adc_sample_i    (adc_sample_i),
    .keypad_number_i (keypad_number_i),
    .uart_byte_i     (uart_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .gate_fire_o     (gate_fire_o),
    .level_o         (level_o),
    .percent_o       (percent_o),
    .source_o        (source_o),
    .armed_o         (armed_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow dimmer state
  source_e           src_sel    = SRC_ADC;
  logic [LevelW-1:0] adc_lvl    = AdcReset;
  logic [LevelW-1:0] key_lvl    = '0;
  logic              key_valid  = 1'b0;
  logic [LevelW-1:0] remote_lvl = '0;
  logic [LevelW-1:0] active_lvl = '0;
  logic [DelayW-1:0] delay_tgt  = '0;
  logic [DelayW-1:0] tick_cnt   = '0;
  logic              fire_armed = 1'b0;

  status_t           pending_status[$];
  int unsigned       fail_count = 0;

  int unsigned burst_left  = 0;
  bit          no_idle     = 1'b0;
  bit          rx_no_stall = 1'b0;
  int unsigned rx_run      = 0;
  bit          rx_on       = 1'b0;

  function automatic status_t advance_dimmer(input logic [ModeW-1:0] ev,
                                             input logic [AdcW-1:0]  adc,
                                             input logic [KeyW-1:0]  key,
                                             input logic [ByteW-1:0] ub);
    status_t           st;
    logic [LevelW-1:0] lv;
    int unsigned       n;
    st.gate_fire = 1'b0;
    case (ev)
      EV_TICK: begin
        if (fire_armed) begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= delay_tgt) begin
            st.gate_fire = 1'b1;
            fire_armed   = 1'b0;
          end
        end
      end
      EV_ZERO: begin
        lv = active_lvl;
        if (src_sel == SRC_ADC) lv = adc_lvl;
        else if (key_valid) lv = key_lvl;
        else if (src_sel == SRC_REMOTE) lv = remote_lvl;
        if (lv > MaxLevel) lv = MaxLevel;
        active_lvl = lv;
        delay_tgt  = FireUs[lv];
        tick_cnt   = '0;
        fire_armed = 1'b1;
      end
      EV_BUTTON: begin
        if (src_sel == SRC_REMOTE) src_sel = SRC_ADC;
        else src_sel = source_e'(src_sel + 1'b1);
        key_valid = 1'b0;
      end
      EV_ADC: begin
        if (src_sel == SRC_ADC) adc_lvl = LevelW'((int'(adc) * 20) / 1023);
      end
      EV_KEYPAD: begin
        if (src_sel == SRC_KEYPAD) begin
          n = (key > KeyClamp) ? int'(KeyClamp) : int'(key);
          key_lvl   = LevelW'((n + 2) / 5);
          key_valid = 1'b1;
        end
      end
      EV_UART: begin
        if (src_sel == SRC_REMOTE && ub >= LetterA && ub <= LetterU)
          remote_lvl = LevelW'(ub - LetterA);
      end
      default: ;
    endcase
    st.level   = active_lvl;
    st.percent = PctW'(active_lvl * 5);
    st.source  = src_sel;
    st.armed   = fire_armed;
    return st;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : status_monitor
    status_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_status.size() == 0) begin
          $error("status beat with no event outstanding");
          fail_count++;
        end else begin
          want = pending_status.pop_front();
          check_field("gate_fire", 16'(want.gate_fire), 16'(gate_fire_o));
          check_field("level",     16'(want.level),     16'(level_o));
          check_field("percent",   16'(want.percent),   16'(percent_o));
          check_field("source",    16'(want.source),    16'(source_o));
          check_field("armed",     16'(want.armed),     16'(armed_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        pending_status.push_back(advance_dimmer(mode_i, adc_sample_i,
                                                keypad_number_i, uart_byte_i));
      end
    end
  end

  // Receiver: alternate ready runs and short stalls
  always @(posedge clk_i) begin
    if (rx_run == 0) begin
      rx_on  = !rx_on;
      rx_run = rx_on ? $urandom_range(1, 24) : $urandom_range(1, 5);
    end
    rx_run--;
    out_ready_i <= rx_on || rx_no_stall;
  end

  initial begin
    repeat (LimitCycles) @(posedge clk_i);
    $display("[phase_angle_triac_dimmer] ERROR");
    $finish;
  end

  task automatic send_ev(input logic [ModeW-1:0] ev, input logic [AdcW-1:0] adc,
                         input logic [KeyW-1:0] key, input logic [ByteW-1:0] ub);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= ev;
    adc_sample_i    <= adc;
    keypad_number_i <= key;
    uart_byte_i     <= ub;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  // Ticks carry random payload that the block must ignore
  task automatic send_ticks(input int unsigned count);
    repeat (count)
      send_ev(EV_TICK, AdcW'($urandom), KeyW'($urandom_range(0, 999)),
              ByteW'($urandom));
  endtask

  task automatic test_reset_and_spare_codes();
    send_ticks(1);
    send_ev(EV_SPARE6, '1, 10'd999, '1);
    send_ev(EV_SPARE7, '0, '0, '0);
  endtask

  task automatic test_adc_source();
    send_ev(EV_ADC, 10'd1023, '0, '0);
    send_ev(EV_ADC, 10'd0, '0, '0);
    send_ev(EV_ZERO, '0, '0, '0);
    send_ev(EV_ADC, 10'd511, '0, '0);
    send_ev(EV_ZERO, '0, '0, '0);
    send_ev(EV_KEYPAD, '0, 10'd50, '0);
    send_ev(EV_UART, '0, '0, LetterA + 8'd10);
    send_ev(EV_ADC, 10'd1023, '0, '0);
    send_ev(EV_ZERO, '0, '0, '0);
  endtask

  task automatic test_keypad_source();
    send_ev(EV_BUTTON, '0, '0, '0);
    // no entry yet: the zero crossing keeps the active level
    send_ev(EV_ZERO, '0, '0, '0);
    send_ev(EV_ADC, 10'd0, '0, '0);
    send_ev(EV_KEYPAD, '0, 10'd999, '0);
    send_ev(EV_KEYPAD, '0, 10'd2, '0);
    send_ev(EV_KEYPAD, '0, 10'd3, '0);
    send_ev(EV_KEYPAD, '0, 10'd57, '0);
    send_ev(EV_ZERO, '0, '0, '0);
  endtask

  task automatic test_remote_source();
    send_ev(EV_BUTTON, '0, '0, '0);
    send_ev(EV_ZERO, '0, '0, '0);
    send_ev(EV_UART, '0, '0, LetterU);
    send_ev(EV_UART, '0, '0, LetterA - 8'd1);
    send_ev(EV_UART, '0, '0, LetterU + 8'd1);
    send_ev(EV_UART, '0, '0, 8'hff);
    send_ev(EV_KEYPAD, '0, 10'd80, '0);
    send_ev(EV_ZERO, '0, '0, '0);
    send_ev(EV_UART, '0, '0, LetterA);
    send_ev(EV_BUTTON, '0, '0, '0);
  endtask

  task automatic test_gate_fire();
    send_ev(EV_ADC, 10'd1023, '0, '0);
    send_ev(EV_ZERO, '0, '0, '0);
    send_ticks(30);
    // re-arm mid-count: the count restarts
    send_ev(EV_ZERO, '0, '0, '0);
    send_ticks(FireUs[20]);
    send_ticks(2);
  endtask

  task automatic send_setup_event();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_ev(EV_BUTTON, AdcW'($urandom), KeyW'($urandom), ByteW'($urandom));
    end else if (pick < 35) begin
      send_ev(EV_ADC, ($urandom_range(0, 9) < 6) ? AdcW'($urandom_range(870, 1023))
                                                 : AdcW'($urandom),
              KeyW'($urandom), ByteW'($urandom));
    end else if (pick < 55) begin
      send_ev(EV_KEYPAD, AdcW'($urandom),
              ($urandom_range(0, 9) < 6) ? KeyW'($urandom_range(78, 999))
                                         : KeyW'($urandom_range(0, 999)),
              ByteW'($urandom));
    end else if (pick < 75) begin
      pick = $urandom_range(0, 9);
      send_ev(EV_UART, AdcW'($urandom), KeyW'($urandom),
              (pick < 6) ? ByteW'($urandom_range(LetterA + 15, LetterU)) :
              (pick < 8) ? ByteW'($urandom_range(LetterA, LetterU)) :
                           ByteW'($urandom));
    end else if (pick < 83) begin
      send_ev($urandom_range(0, 1) ? EV_SPARE6 : EV_SPARE7, AdcW'($urandom),
              KeyW'($urandom), ByteW'($urandom));
    end else if (pick < 93) begin
      send_ticks($urandom_range(1, 3));
    end else begin
      send_ev(EV_ZERO, AdcW'($urandom), KeyW'($urandom), ByteW'($urandom));
    end
  endtask

  task automatic test_random_half_cycles();
    for (int unsigned i = 0; i < NumHalfCycles; i++) begin
      no_idle     = ($urandom_range(0, 3) == 0);
      rx_no_stall = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 15)) send_setup_event();
      send_ev(EV_ZERO, AdcW'($urandom), KeyW'($urandom), ByteW'($urandom));
      // stop the count well short of the shortest delay
      send_ticks($urandom_range(0, 20));
    end
    no_idle     = 1'b0;
    rx_no_stall = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_and_spare_codes();
    test_adc_source();
    test_keypad_source();
    test_remote_source();
    test_gate_fire();
    test_random_half_cycles();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[phase_angle_triac_dimmer] OK");
    end else begin
      $display("[phase_angle_triac_dimmer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
